// ===== rtl/rbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Relay button controller package
// Shared widths, register map, codes, control structs and the click-action
// lookup used by the relay button controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rbc_pkg;

  // Default sizing of the channel array and the per-channel timers
  localparam int CHANNELS_DEF   = 4;
  localparam int TIMER_BITS_DEF = 16;

  // Field widths of the item and result channels
  localparam int KEY_W       = 4;
  localparam int CH_FIELD_W  = 2;
  localparam int ACT_W       = 2;
  localparam int CLICK_CNT_W = 8;
  localparam int CLICK_ACT_W = 3;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_MODE         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_INTERLOCK_ENABLE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERSIST_ENABLE   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLICK_TIMEOUT_MS = 3'd5;

  // Register reset values
  localparam logic [2:0]  RST_CHANNEL_COUNT    = 3'd1;
  localparam logic [1:0]  RST_KEY_MODE         = 2'd0;
  localparam logic        RST_INTERLOCK_ENABLE = 1'b0;
  localparam logic        RST_PERSIST_ENABLE   = 1'b0;
  localparam logic [9:0]  RST_DEBOUNCE_MS      = 10'd50;
  localparam logic [13:0] RST_CLICK_TIMEOUT_MS = 14'd1000;

  // Item kinds
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_COMMAND = 1'b1;

  // Command actions (the two unused codes toggle the relay)
  localparam logic [ACT_W-1:0] ACT_OFF    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ON     = 2'd1;

  // Switch modes (the unused code behaves as auto)
  localparam logic [1:0] MODE_AUTO      = 2'd0;
  localparam logic [1:0] MODE_MOMENTARY = 2'd1;
  localparam logic [1:0] MODE_LATCHING  = 2'd2;

  // Gap that must be exceeded between two toggles in auto mode, in ms
  localparam int AUTO_GAP_MS = 300;

  // Click bursts with a special meaning
  localparam logic [CLICK_CNT_W-1:0] CLICKS_LEARN      = 8'd10;
  localparam logic [CLICK_CNT_W-1:0] CLICKS_DELETE     = 8'd12;
  localparam logic [CLICK_CNT_W-1:0] CLICKS_DELETE_ALL = 8'd16;
  localparam logic [CLICK_CNT_W-1:0] CLICKS_WIFI_SETUP = 8'd20;

  localparam logic [CLICK_ACT_W-1:0] CLICK_NONE       = 3'd0;
  localparam logic [CLICK_ACT_W-1:0] CLICK_LEARN      = 3'd1;
  localparam logic [CLICK_ACT_W-1:0] CLICK_DELETE     = 3'd2;
  localparam logic [CLICK_ACT_W-1:0] CLICK_DELETE_ALL = 3'd3;
  localparam logic [CLICK_ACT_W-1:0] CLICK_WIFI_SETUP = 3'd4;

  // Configuration register set
  typedef struct packed {
    logic [2:0]  channel_count;
    logic [1:0]  key_mode;
    logic        interlock_enable;
    logic        persist_enable;
    logic [9:0]  debounce_ms;
    logic [13:0] click_timeout_ms;
  } cfg_t;

  // Result of one item
  typedef struct packed {
    logic [KEY_W-1:0]       relay_state;
    logic [KEY_W-1:0]       changed_mask;
    logic [KEY_W-1:0]       persist_mask;
    logic                   click_valid;
    logic [CH_FIELD_W-1:0]  click_channel;
    logic [CLICK_CNT_W-1:0] click_count;
    logic [CLICK_ACT_W-1:0] click_action;
    logic                   cmd_error;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch a new item, clear the accumulators
    logic tick_step;  // process one channel of a tick
    logic cmd_step;   // apply a relay command
    logic capture;    // move the finished result to the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic none;       // no channel in use
    logic last;       // the current channel is the last one in use
  } dp_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CMD,
    ST_DONE
  } rbc_state_e;

  // Special action of a finished click burst
  function automatic logic [CLICK_ACT_W-1:0] click_action_of(
      input logic [CLICK_CNT_W-1:0] count);
    logic [CLICK_ACT_W-1:0] act;
    act = CLICK_NONE;
    case (count)
      CLICKS_LEARN:      act = CLICK_LEARN;
      CLICKS_DELETE:     act = CLICK_DELETE;
      CLICKS_DELETE_ALL: act = CLICK_DELETE_ALL;
      CLICKS_WIFI_SETUP: act = CLICK_WIFI_SETUP;
      default:           act = CLICK_NONE;
    endcase
    return act;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rbc_in_if.sv =====
// ----------------------------------------------------------------------------
// Relay button controller item channel
// Valid/ready channel carrying one tick or relay command per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbc_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [rbc_pkg::KEY_W-1:0]      key_levels;
  logic [rbc_pkg::CH_FIELD_W-1:0] cmd_channel;
  logic [rbc_pkg::ACT_W-1:0]      cmd_action;
  logic                           cmd_save;

  modport source (
    output valid, func, key_levels, cmd_channel, cmd_action, cmd_save,
    input  ready
  );

  modport sink (
    input  valid, func, key_levels, cmd_channel, cmd_action, cmd_save,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rbc_out_if.sv =====
// ----------------------------------------------------------------------------
// Relay button controller result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbc_out_if;
  logic                            valid;
  logic                            ready;
  logic [rbc_pkg::KEY_W-1:0]       relay_state;
  logic [rbc_pkg::KEY_W-1:0]       changed_mask;
  logic [rbc_pkg::KEY_W-1:0]       persist_mask;
  logic                            click_valid;
  logic [rbc_pkg::CH_FIELD_W-1:0]  click_channel;
  logic [rbc_pkg::CLICK_CNT_W-1:0] click_count;
  logic [rbc_pkg::CLICK_ACT_W-1:0] click_action;
  logic                            cmd_error;

  modport source (
    output valid, relay_state, changed_mask, persist_mask, click_valid,
           click_channel, click_count, click_action, cmd_error,
    input  ready
  );

  modport sink (
    input  valid, relay_state, changed_mask, persist_mask, click_valid,
           click_channel, click_count, click_action, cmd_error,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/rbc_cfg.sv =====
// ----------------------------------------------------------------------------
// Relay button controller register file
// APB-style register block holding the six configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rbc_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rbc_pkg::APB_DATA_W-1:0]   pwdata,
  output      logic [rbc_pkg::APB_DATA_W-1:0]   prdata,
  output      logic                             pready,
  output      rbc_pkg::cfg_t                    cfg_o
);

  rbc_pkg::cfg_t                   cfg_q, cfg_d;
  logic [rbc_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                            wr_en;

  assign reg_idx = paddr[rbc_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  // Decode a register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        rbc_pkg::REG_CHANNEL_COUNT:    cfg_d.channel_count    = pwdata[2:0];
        rbc_pkg::REG_KEY_MODE:         cfg_d.key_mode         = pwdata[1:0];
        rbc_pkg::REG_INTERLOCK_ENABLE: cfg_d.interlock_enable = pwdata[0];
        rbc_pkg::REG_PERSIST_ENABLE:   cfg_d.persist_enable   = pwdata[0];
        rbc_pkg::REG_DEBOUNCE_MS:      cfg_d.debounce_ms      = pwdata[9:0];
        rbc_pkg::REG_CLICK_TIMEOUT_MS: cfg_d.click_timeout_ms = pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_count    <= rbc_pkg::RST_CHANNEL_COUNT;
      cfg_q.key_mode         <= rbc_pkg::RST_KEY_MODE;
      cfg_q.interlock_enable <= rbc_pkg::RST_INTERLOCK_ENABLE;
      cfg_q.persist_enable   <= rbc_pkg::RST_PERSIST_ENABLE;
      cfg_q.debounce_ms      <= rbc_pkg::RST_DEBOUNCE_MS;
      cfg_q.click_timeout_ms <= rbc_pkg::RST_CLICK_TIMEOUT_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    case (reg_idx)
      rbc_pkg::REG_CHANNEL_COUNT:    prdata = 32'(cfg_q.channel_count);
      rbc_pkg::REG_KEY_MODE:         prdata = 32'(cfg_q.key_mode);
      rbc_pkg::REG_INTERLOCK_ENABLE: prdata = 32'(cfg_q.interlock_enable);
      rbc_pkg::REG_PERSIST_ENABLE:   prdata = 32'(cfg_q.persist_enable);
      rbc_pkg::REG_DEBOUNCE_MS:      prdata = 32'(cfg_q.debounce_ms);
      rbc_pkg::REG_CLICK_TIMEOUT_MS: prdata = 32'(cfg_q.click_timeout_ms);
      default:                       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// Relay button controller sequencer
// Accepts an item, walks the datapath through the channels of a tick or one
// command step, and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_ctrl #(
  parameter int CHANNELS = rbc_pkg::CHANNELS_DEF,
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_func_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire rbc_pkg::dp_stat_t stat_i,
  output      rbc_pkg::dp_cmd_t  cmd_o,
  output      logic [CH_W-1:0]   ch_o
);

  rbc_pkg::rbc_state_e state_q, state_d;
  logic [CH_W-1:0]     ch_q, ch_d;
  logic                out_valid_q, out_valid_d;

  assign ch_o        = ch_q;
  assign out_valid_o = out_valid_q;

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      rbc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ch_d       = '0;
          if (in_func_i == rbc_pkg::FUNC_COMMAND) begin
            state_d = rbc_pkg::ST_CMD;
          end else if (stat_i.none) begin
            state_d = rbc_pkg::ST_DONE;
          end else begin
            state_d = rbc_pkg::ST_TICK;
          end
        end
      end
      rbc_pkg::ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (stat_i.last) begin
          state_d = rbc_pkg::ST_DONE;
        end else begin
          ch_d = ch_q + CH_W'(1);
        end
      end
      rbc_pkg::ST_CMD: begin
        cmd_o.cmd_step = 1'b1;
        state_d        = rbc_pkg::ST_DONE;
      end
      rbc_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = rbc_pkg::ST_IDLE;
        end
      end
      default: state_d = rbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbc_pkg::ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rbc_dp.sv =====
// ----------------------------------------------------------------------------
// Relay button controller datapath
// Per-channel debounce, click and gap timers, relay bits, result
// accumulators and the output register. One channel is updated per step.
// ----------------------------------------------------------------------------
`default_nettype none

module rbc_dp #(
  parameter int CHANNELS   = rbc_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = rbc_pkg::TIMER_BITS_DEF,
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire rbc_pkg::cfg_t                    cfg_i,
  input  wire rbc_pkg::dp_cmd_t                 cmd_i,
  input  wire logic [CH_W-1:0]                  ch_i,
  output      rbc_pkg::dp_stat_t                stat_o,
  input  wire logic                             func_i,
  input  wire logic [rbc_pkg::KEY_W-1:0]        key_levels_i,
  input  wire logic [rbc_pkg::CH_FIELD_W-1:0]   cmd_channel_i,
  input  wire logic [rbc_pkg::ACT_W-1:0]        cmd_action_i,
  input  wire logic                             cmd_save_i,
  output      rbc_pkg::result_t                 result_o
);

  localparam int CNT_W = $clog2(CHANNELS + 1);
  localparam int CMP_W = (TIMER_BITS > 14) ? TIMER_BITS : 14;
  localparam int CC_W  = rbc_pkg::CLICK_CNT_W;

  // Latched item
  logic                            func_q;
  logic [rbc_pkg::KEY_W-1:0]       keys_q;
  logic [rbc_pkg::CH_FIELD_W-1:0]  cch_q;
  logic [rbc_pkg::ACT_W-1:0]       act_q;
  logic                            save_q;

  // Channel state
  logic [CHANNELS-1:0]   unst_q, unst_d;
  logic [CHANNELS-1:0]   deb_q, deb_d;
  logic [CHANNELS-1:0]   relay_q, relay_d;
  logic [TIMER_BITS-1:0] db_tmr_q [CHANNELS];
  logic [TIMER_BITS-1:0] bt_tmr_q [CHANNELS];
  logic [TIMER_BITS-1:0] gap_tmr_q [CHANNELS];
  logic [CC_W-1:0]       clicks_q [CHANNELS];

  // Accumulators for the item in progress
  logic [CHANNELS-1:0]               chg_q, chg_d;
  logic [CHANNELS-1:0]               per_q, per_d;
  logic                              cv_q, cv_d;
  logic [CH_W-1:0]                   cch_acc_q, cch_acc_d;
  logic [CC_W-1:0]                   ccnt_q, ccnt_d;
  logic [rbc_pkg::CLICK_ACT_W-1:0]   cact_q, cact_d;
  logic                              err_q, err_d;

  rbc_pkg::result_t res_q, res_d;

  // Step values
  logic [CNT_W-1:0]      n_act;
  logic [CHANNELS-1:0]   act_mask;
  logic [CHANNELS-1:0]   keys_ext;
  logic [TIMER_BITS-1:0] dt_n, bt_n, gt_n;
  logic [CC_W-1:0]       cnt_n;
  logic                  raw;
  logic                  do_set, set_on, set_save;
  logic [CH_W-1:0]       set_ch;
  logic [CHANNELS-1:0]   set_bit, clr_m;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
    return (&t) ? t : t + TIMER_BITS'(1);
  endfunction

  // Effective channel count and mask of channels in use
  always_comb begin
    if (32'(cfg_i.channel_count) < 32'(CHANNELS)) begin
      n_act = CNT_W'(cfg_i.channel_count);
    end else begin
      n_act = CNT_W'(CHANNELS);
    end
    for (int k = 0; k < CHANNELS; k++) begin
      act_mask[k] = (CNT_W'(k) < n_act);
    end
  end

  assign stat_o.none = (n_act == '0);
  assign stat_o.last = ((CNT_W'(ch_i) + CNT_W'(1)) == n_act);

  // Channels without a key pin read as released
  for (genvar g = 0; g < CHANNELS; g++) begin : g_keys
    if (g < rbc_pkg::KEY_W) begin : g_pin
      assign keys_ext[g] = keys_q[g];
    end else begin : g_nopin
      assign keys_ext[g] = 1'b1;
    end
  end

  // One tick step or command step
  always_comb begin
    unst_d    = unst_q;
    deb_d     = deb_q;
    chg_d     = chg_q;
    per_d     = per_q;
    cv_d      = cv_q;
    cch_acc_d = cch_acc_q;
    ccnt_d    = ccnt_q;
    cact_d    = cact_q;
    err_d     = err_q;
    dt_n      = sat_inc(db_tmr_q[ch_i]);
    bt_n      = sat_inc(bt_tmr_q[ch_i]);
    gt_n      = sat_inc(gap_tmr_q[ch_i]);
    cnt_n     = clicks_q[ch_i];
    raw       = keys_ext[ch_i];
    do_set    = 1'b0;
    set_on    = 1'b0;
    set_save  = 1'b0;
    set_ch    = ch_i;

    if (cmd_i.tick_step) begin
      if (raw != unst_q[ch_i]) begin
        dt_n          = '0;
        unst_d[ch_i]  = raw;
      end else if ((dt_n >= TIMER_BITS'(cfg_i.debounce_ms)) && (raw != deb_q[ch_i])) begin
        // Debounced edge: count a click and maybe toggle
        dt_n         = '0;
        deb_d[ch_i]  = raw;
        if (cnt_n != '1) begin
          cnt_n = cnt_n + CC_W'(1);
        end
        bt_n     = '0;
        set_on   = !relay_q[ch_i];
        set_save = 1'b1;
        case (cfg_i.key_mode)
          rbc_pkg::MODE_MOMENTARY: do_set = !raw;
          rbc_pkg::MODE_LATCHING:  do_set = 1'b1;
          default: begin
            if (gt_n > TIMER_BITS'(rbc_pkg::AUTO_GAP_MS)) begin
              do_set = 1'b1;
              gt_n   = '0;
            end
          end
        endcase
      end
      // End of a click burst
      if ((cnt_n != '0) && (CMP_W'(bt_n) > CMP_W'(cfg_i.click_timeout_ms))) begin
        if (!cv_q) begin
          cv_d      = 1'b1;
          cch_acc_d = ch_i;
          ccnt_d    = cnt_n;
          cact_d    = rbc_pkg::click_action_of(cnt_n);
        end
        cnt_n = '0;
      end
    end else if (cmd_i.cmd_step) begin
      if (32'(cch_q) >= 32'(n_act)) begin
        err_d = 1'b1;
      end else begin
        do_set   = 1'b1;
        set_ch   = CH_W'(cch_q);
        set_save = save_q;
        case (act_q)
          rbc_pkg::ACT_OFF: set_on = 1'b0;
          rbc_pkg::ACT_ON:  set_on = 1'b1;
          default:          set_on = !relay_q[CH_W'(cch_q)];
        endcase
      end
    end
  end

  // Relay switch with interlock
  always_comb begin
    relay_d = relay_q;
    set_bit = CHANNELS'(1) << set_ch;
    clr_m   = '0;
    if (do_set) begin
      if (set_on && cfg_i.interlock_enable) begin
        clr_m = relay_q & act_mask & ~set_bit;
      end
      relay_d = relay_q & ~clr_m;
      if (relay_d[set_ch] != set_on) begin
        clr_m = clr_m | set_bit;
      end
      relay_d[set_ch] = set_on;
    end
  end

  // Result to the output register
  always_comb begin
    res_d               = res_q;
    res_d.relay_state   = rbc_pkg::KEY_W'(relay_q);
    res_d.changed_mask  = rbc_pkg::KEY_W'(chg_q);
    res_d.persist_mask  = rbc_pkg::KEY_W'(per_q);
    res_d.click_valid   = cv_q;
    res_d.click_channel = rbc_pkg::CH_FIELD_W'(cch_acc_q);
    res_d.click_count   = ccnt_q;
    res_d.click_action  = cact_q;
    res_d.cmd_error     = err_q;
  end

  assign result_o = res_q;

  // Control and channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unst_q  <= '1;
      deb_q   <= '1;
      relay_q <= '0;
      for (int k = 0; k < CHANNELS; k++) begin
        db_tmr_q[k]  <= '0;
        bt_tmr_q[k]  <= '0;
        gap_tmr_q[k] <= '0;
        clicks_q[k]  <= '0;
      end
    end else if (cmd_i.tick_step || cmd_i.cmd_step) begin
      unst_q  <= unst_d;
      deb_q   <= deb_d;
      relay_q <= relay_d;
      if (cmd_i.tick_step) begin
        db_tmr_q[ch_i]  <= dt_n;
        bt_tmr_q[ch_i]  <= bt_n;
        gap_tmr_q[ch_i] <= gt_n;
        clicks_q[ch_i]  <= cnt_n;
      end
    end
  end

  // Item latch and accumulators
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q    <= func_i;
      keys_q    <= key_levels_i;
      cch_q     <= cmd_channel_i;
      act_q     <= cmd_action_i;
      save_q    <= cmd_save_i;
      chg_q     <= '0;
      per_q     <= '0;
      cv_q      <= 1'b0;
      cch_acc_q <= '0;
      ccnt_q    <= '0;
      cact_q    <= rbc_pkg::CLICK_NONE;
      err_q     <= 1'b0;
    end else if (cmd_i.tick_step || cmd_i.cmd_step) begin
      chg_q     <= chg_d | clr_m;
      per_q     <= per_d | ((set_save && cfg_i.persist_enable && do_set)
                            ? ((relay_q & ~relay_d) | set_bit) & (clr_m | set_bit)
                            : '0);
      cv_q      <= cv_d;
      cch_acc_q <= cch_acc_d;
      ccnt_q    <= ccnt_d;
      cact_q    <= cact_d;
      err_q     <= err_d || (func_q && !cmd_i.tick_step && err_d);
    end
    if (cmd_i.capture) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/relay_button_controller.sv =====
// ----------------------------------------------------------------------------
// Relay button controller
// Four-channel relay controller with debounced keys, click bursts, relay
// commands and interlock, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one transaction per item: a 1 ms tick with the raw key
//   levels (func 0) or a relay command (func 1). out_o returns exactly one
//   result transaction per item, in order. Registers are written over the
//   APB port (psel/penable/pwrite, pready always high) while the block is idle.
// Sequencing:
//   After acceptance a tick runs one step of the shared channel datapath per
//   channel in use, then writes the result to the output register. A command
//   runs a single command step and then writes the result; a tick with no
//   channel in use writes its result directly. The next item is accepted in
//   the cycle after the result is written.
// Reset:
//   rst_ni clears relays, timers and click counts, sets all keys released and
//   loads the register defaults. No clearing pass is needed.
// Stalls:
//   The output register holds a result until it is taken. One more item is
//   accepted meanwhile; its result waits in the datapath, and no further item
//   is accepted, until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module relay_button_controller #(
  parameter int CHANNELS   = rbc_pkg::CHANNELS_DEF,
  parameter int TIMER_BITS = rbc_pkg::TIMER_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rbc_in_if.sink                               in_i,
  rbc_out_if.source                            out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [rbc_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [rbc_pkg::APB_DATA_W-1:0]  pwdata,
  output      logic [rbc_pkg::APB_DATA_W-1:0]  prdata,
  output      logic                            pready
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  rbc_pkg::cfg_t     cfg;
  rbc_pkg::dp_cmd_t  dp_cmd;
  rbc_pkg::dp_stat_t dp_stat;
  rbc_pkg::result_t  result;
  logic [CH_W-1:0]   cur_ch;

  rbc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rbc_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd),
    .ch_o        (cur_ch)
  );

  rbc_dp #(
    .CHANNELS   (CHANNELS),
    .TIMER_BITS (TIMER_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (dp_cmd),
    .ch_i          (cur_ch),
    .stat_o        (dp_stat),
    .func_i        (in_i.func),
    .key_levels_i  (in_i.key_levels),
    .cmd_channel_i (in_i.cmd_channel),
    .cmd_action_i  (in_i.cmd_action),
    .cmd_save_i    (in_i.cmd_save),
    .result_o      (result)
  );

  // Drive the result channel from the output register
  assign out_o.relay_state   = result.relay_state;
  assign out_o.changed_mask  = result.changed_mask;
  assign out_o.persist_mask  = result.persist_mask;
  assign out_o.click_valid   = result.click_valid;
  assign out_o.click_channel = result.click_channel;
  assign out_o.click_count   = result.click_count;
  assign out_o.click_action  = result.click_action;
  assign out_o.cmd_error     = result.cmd_error;

endmodule

`default_nettype wire

// ===== tb/relay_button_controller_tb.sv =====
// ----------------------------------------------------------------------------
// Relay button controller testbench
// Drives ticks and relay commands into the controller and checks every result
// against a cycle-free behavioral predictor of the debouncer, click bursts,
// relay switching, interlock and persistence. Directed tests cover commands,
// channel limits, register defaults and extremes, and bursts that end together.
// Random tests run click bursts with random content under several register
// settings, with random idling on the item and result channels.
// ----------------------------------------------------------------------------
module relay_button_controller_tb;
  import rbc_pkg::*;

  // Codes that the package leaves unnamed
  localparam logic [ACT_W-1:0] ACT_TOGGLE     = 2'd2;
  localparam logic [ACT_W-1:0] ACT_TOGGLE_ALT = 2'd3;
  localparam logic [1:0]       MODE_SPARE     = 2'd3;

  localparam logic [KEY_W-1:0] KEYS_PRESSED  = 4'h0;
  localparam logic [KEY_W-1:0] KEYS_RELEASED = 4'hF;

  localparam int NCH     = CHANNELS_DEF;
  localparam int TIMER_W = TIMER_BITS_DEF;

  typedef struct packed {
    logic                  func;
    logic [KEY_W-1:0]      keys;
    logic [CH_FIELD_W-1:0] channel;
    logic [ACT_W-1:0]      action;
    logic                  save;
  } relay_item_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  rbc_in_if  in_if ();
  rbc_out_if out_if ();

  relay_button_controller dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state and register shadow
  cfg_t               shadow_cfg;
  logic [KEY_W-1:0]   key_seen;
  logic [KEY_W-1:0]   key_stable;
  logic [TIMER_W-1:0] settle_ms [NCH];
  logic [TIMER_W-1:0] burst_ms [NCH];
  logic [TIMER_W-1:0] gap_ms [NCH];
  logic [7:0]         click_tally [NCH];
  logic [KEY_W-1:0]   relay_model;
  logic [KEY_W-1:0]   switched_bits;
  logic [KEY_W-1:0]   saved_bits;

  result_t          pending_results [$];
  logic [KEY_W-1:0] keys_now;
  int               items_sent;
  int               mismatches;
  int               stall_left;
  bit               gaps_on;
  bit               stalls_on;

  function automatic int channels_in_use();
    return (shadow_cfg.channel_count < NCH) ? int'(shadow_cfg.channel_count) : NCH;
  endfunction

  function automatic logic [TIMER_W-1:0] sat_bump(input logic [TIMER_W-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  // Switch one relay; interlock drops the others first when it turns on
  function automatic void drive_relay(input int ch, input logic on, input logic save);
    int n;
    n = channels_in_use();
    if (on && shadow_cfg.interlock_enable) begin
      for (int k = 0; k < n; k++) begin
        if (k != ch && relay_model[k]) begin
          relay_model[k]   = 1'b0;
          switched_bits[k] = 1'b1;
          if (save && shadow_cfg.persist_enable) saved_bits[k] = 1'b1;
        end
      end
    end
    if (relay_model[ch] != on) switched_bits[ch] = 1'b1;
    relay_model[ch] = on;
    if (save && shadow_cfg.persist_enable) saved_bits[ch] = 1'b1;
  endfunction

  // Advance the predictor by one item and return the result it causes
  function automatic result_t predict_relay_result(input relay_item_t txn);
    result_t r;
    int      n;
    logic    on;
    logic    raw;
    r = '0;
    switched_bits = '0;
    saved_bits = '0;
    n = channels_in_use();
    if (txn.func == FUNC_COMMAND) begin
      if (txn.channel >= n) begin
        r.cmd_error = 1'b1;
      end else begin
        if (txn.action == ACT_OFF) on = 1'b0;
        else if (txn.action == ACT_ON) on = 1'b1;
        else on = ~relay_model[txn.channel];
        drive_relay(int'(txn.channel), on, txn.save);
      end
    end else begin
      for (int c = 0; c < n; c++) begin
        raw = txn.keys[c];
        settle_ms[c] = sat_bump(settle_ms[c]);
        burst_ms[c]  = sat_bump(burst_ms[c]);
        gap_ms[c]    = sat_bump(gap_ms[c]);
        if (raw != key_seen[c]) begin
          settle_ms[c] = '0;
          key_seen[c]  = raw;
        end else if (settle_ms[c] >= shadow_cfg.debounce_ms && raw != key_stable[c]) begin
          settle_ms[c]  = '0;
          key_stable[c] = raw;
          if (click_tally[c] != 8'hFF) click_tally[c] = click_tally[c] + 1'b1;
          burst_ms[c] = '0;
          on = ~relay_model[c];
          case (shadow_cfg.key_mode)
            MODE_MOMENTARY: begin
              if (!raw) drive_relay(c, on, 1'b1);
            end
            MODE_LATCHING: begin
              drive_relay(c, on, 1'b1);
            end
            default: begin
              if (gap_ms[c] > AUTO_GAP_MS) begin
                drive_relay(c, on, 1'b1);
                gap_ms[c] = '0;
              end
            end
          endcase
        end
        // Report the lowest ended burst, clear all of them
        if (click_tally[c] != 0 && burst_ms[c] > shadow_cfg.click_timeout_ms) begin
          if (!r.click_valid) begin
            r.click_valid   = 1'b1;
            r.click_channel = CH_FIELD_W'(c);
            r.click_count   = click_tally[c];
            case (click_tally[c])
              CLICKS_LEARN:      r.click_action = CLICK_LEARN;
              CLICKS_DELETE:     r.click_action = CLICK_DELETE;
              CLICKS_DELETE_ALL: r.click_action = CLICK_DELETE_ALL;
              CLICKS_WIFI_SETUP: r.click_action = CLICK_WIFI_SETUP;
              default:           r.click_action = CLICK_NONE;
            endcase
          end
          click_tally[c] = '0;
        end
      end
    end
    r.relay_state  = relay_model;
    r.changed_mask = switched_bits;
    r.persist_mask = saved_bits;
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Compare each result transaction with the oldest expectation, draw stalls
  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual relay_state %0h",
                 $time, out_if.relay_state);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("relay_state", 32'(want.relay_state), 32'(out_if.relay_state));
        check_field("changed_mask", 32'(want.changed_mask), 32'(out_if.changed_mask));
        check_field("persist_mask", 32'(want.persist_mask), 32'(out_if.persist_mask));
        check_field("click_valid", 32'(want.click_valid), 32'(out_if.click_valid));
        check_field("click_channel", 32'(want.click_channel), 32'(out_if.click_channel));
        check_field("click_count", 32'(want.click_count), 32'(out_if.click_count));
        check_field("click_action", 32'(want.click_action), 32'(out_if.click_action));
        check_field("cmd_error", 32'(want.cmd_error), 32'(out_if.cmd_error));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Send one item; valid stays high after the transaction
  task automatic send_item(input relay_item_t txn);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.func        <= txn.func;
    in_if.key_levels  <= txn.keys;
    in_if.cmd_channel <= txn.channel;
    in_if.cmd_action  <= txn.action;
    in_if.cmd_save    <= txn.save;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(predict_relay_result(txn));
    items_sent++;
  endtask

  task automatic send_tick(input logic [KEY_W-1:0] keys);
    relay_item_t txn;
    txn.func    = FUNC_TICK;
    txn.keys    = keys;
    txn.channel = CH_FIELD_W'($urandom_range(0, 3));
    txn.action  = ACT_W'($urandom_range(0, 3));
    txn.save    = 1'($urandom_range(0, 1));
    send_item(txn);
  endtask

  task automatic send_cmd(input logic [CH_FIELD_W-1:0] channel,
                          input logic [ACT_W-1:0] action, input logic save);
    relay_item_t txn;
    txn.func    = FUNC_COMMAND;
    txn.keys    = KEY_W'($urandom_range(0, 15));
    txn.channel = channel;
    txn.action  = action;
    txn.save    = save;
    send_item(txn);
  endtask

  // Hold the sender until every expected result has arrived
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CHANNEL_COUNT:    shadow_cfg.channel_count    = value[2:0];
      REG_KEY_MODE:         shadow_cfg.key_mode         = value[1:0];
      REG_INTERLOCK_ENABLE: shadow_cfg.interlock_enable = value[0];
      REG_PERSIST_ENABLE:   shadow_cfg.persist_enable   = value[0];
      REG_DEBOUNCE_MS:      shadow_cfg.debounce_ms      = value[9:0];
      REG_CLICK_TIMEOUT_MS: shadow_cfg.click_timeout_ms = value[13:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int count, input logic [1:0] mode, input bit ilock,
                           input bit persist, input int debounce, input int timeout);
    set_reg(REG_CHANNEL_COUNT, count);
    set_reg(REG_KEY_MODE, APB_DATA_W'(mode));
    set_reg(REG_INTERLOCK_ENABLE, APB_DATA_W'(ilock));
    set_reg(REG_PERSIST_ENABLE, APB_DATA_W'(persist));
    set_reg(REG_DEBOUNCE_MS, debounce);
    set_reg(REG_CLICK_TIMEOUT_MS, timeout);
  endtask

  // Toggle one key a number of times, each level held past the debounce,
  // then let the burst time out
  task automatic click_burst(input int ch, input int edges, input int hold_extra);
    for (int e = 0; e < edges; e++) begin
      keys_now[ch] = ~keys_now[ch];
      repeat (shadow_cfg.debounce_ms + 1 + $urandom_range(0, hold_extra)) send_tick(keys_now);
    end
    repeat (shadow_cfg.click_timeout_ms + 1 + $urandom_range(0, 3)) send_tick(keys_now);
  endtask

  // Mostly click bursts, some commands, some key noise and the odd drain
  task automatic run_mixed(input int budget);
    int stop_at;
    int pick;
    int edges;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        case ($urandom_range(0, 7))
          0: edges = 10;
          1: edges = 12;
          2: edges = 16;
          3: edges = 20;
          default: edges = $urandom_range(1, 7);
        endcase
        click_burst($urandom_range(0, 3), edges, 2);
      end else if (pick < 8) begin
        send_cmd(CH_FIELD_W'($urandom_range(0, 3)), ACT_W'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) == 0) drain_results();
        repeat ($urandom_range(1, 8)) begin
          keys_now = KEY_W'($urandom_range(0, 15));
          send_tick(keys_now);
        end
      end
    end
  endtask

  // Register defaults: one channel, auto mode
  task automatic test_reset_defaults();
    send_cmd(2'd1, ACT_ON, 1'b1);
    send_cmd(2'd0, ACT_TOGGLE_ALT, 1'b1);
    send_tick(KEYS_PRESSED);
  endtask

  // Every action, interlock, persistence and repeated switches
  task automatic test_relay_commands();
    configure(4, MODE_LATCHING, 1'b1, 1'b1, 1, 8);
    send_cmd(2'd0, ACT_ON, 1'b1);
    send_cmd(2'd1, ACT_ON, 1'b1);
    send_cmd(2'd3, ACT_ON, 1'b0);
    send_cmd(2'd3, ACT_TOGGLE, 1'b1);
    send_cmd(2'd2, ACT_TOGGLE_ALT, 1'b1);
    send_cmd(2'd2, ACT_OFF, 1'b0);
    send_cmd(2'd2, ACT_OFF, 1'b1);
  endtask

  // Zero, clamped and partial channel counts
  task automatic test_channel_limits();
    set_reg(REG_CHANNEL_COUNT, 0);
    send_cmd(2'd0, ACT_ON, 1'b1);
    send_tick(KEYS_PRESSED);
    set_reg(REG_CHANNEL_COUNT, 7);
    send_cmd(2'd3, ACT_ON, 1'b1);
    set_reg(REG_CHANNEL_COUNT, 2);
    send_cmd(2'd2, ACT_ON, 1'b1);
    send_cmd(2'd3, ACT_TOGGLE, 1'b0);
    send_tick(KEYS_RELEASED);
  endtask

  // All keys at once so that several bursts end on the same tick
  task automatic test_simultaneous_bursts();
    configure(4, MODE_LATCHING, 1'b0, 1'b1, 1, 1);
    repeat (4) send_tick(KEYS_PRESSED);
    repeat (4) send_tick(KEYS_RELEASED);
    keys_now = KEYS_RELEASED;
  endtask

  task automatic test_register_extremes();
    configure(4, MODE_MOMENTARY, 1'b0, 1'b0, 1000, 10000);
    repeat (5) send_tick(KEYS_PRESSED);
    send_cmd(2'd1, ACT_TOGGLE, 1'b1);
    send_tick(KEYS_RELEASED);
  endtask

  // Auto mode right after few ticks: toggles held off until the gap has passed
  task automatic test_auto_gap();
    configure(3, MODE_AUTO, 1'b1, 1'b0, 1, 5);
    run_mixed(300);
  endtask

  task automatic test_click_saturation();
    configure(4, MODE_LATCHING, 1'b0, 1'b1, 1, 8);
    click_burst(1, 258, 0);
    run_mixed(30);
  endtask

  task automatic test_momentary_interlock();
    configure(4, MODE_MOMENTARY, 1'b1, 1'b1, 2, 12);
    run_mixed(60);
  endtask

  task automatic test_spare_mode();
    configure(2, MODE_SPARE, 1'b0, 1'b1, 3, 20);
    run_mixed(50);
  endtask

  // Last stretch at full rate on both sides
  task automatic test_full_rate();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    configure(7, MODE_LATCHING, 1'b1, 1'b0, 1, 1);
    run_mixed(80);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.func           = FUNC_TICK;
    in_if.key_levels     = KEYS_RELEASED;
    in_if.cmd_channel    = '0;
    in_if.cmd_action     = ACT_OFF;
    in_if.cmd_save       = 1'b0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    shadow_cfg.channel_count    = RST_CHANNEL_COUNT;
    shadow_cfg.key_mode         = RST_KEY_MODE;
    shadow_cfg.interlock_enable = RST_INTERLOCK_ENABLE;
    shadow_cfg.persist_enable   = RST_PERSIST_ENABLE;
    shadow_cfg.debounce_ms      = RST_DEBOUNCE_MS;
    shadow_cfg.click_timeout_ms = RST_CLICK_TIMEOUT_MS;
    key_seen    = KEYS_RELEASED;
    key_stable  = KEYS_RELEASED;
    relay_model = '0;
    for (int c = 0; c < NCH; c++) begin
      settle_ms[c]   = '0;
      burst_ms[c]    = '0;
      gap_ms[c]      = '0;
      click_tally[c] = '0;
    end
    keys_now   = KEYS_RELEASED;
    items_sent = 0;
    mismatches = 0;
    stall_left = 0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_relay_commands();
    test_channel_limits();
    test_simultaneous_bursts();
    test_register_extremes();
    test_auto_gap();
    test_click_saturation();
    test_momentary_interlock();
    test_spare_mode();
    test_full_rate();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

endmodule
